// ----- hdl/pbs_pkg.sv -----
// Shared types and default constants for the priority bracket stack.
package pbs_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int unsigned DEF_STACK_DEPTH = 64;
    localparam int unsigned DEF_PAIR_KINDS  = 64;
    localparam int unsigned DEF_RANK_BITS   = 8;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_TOKEN = 2'd0,
        OP_TRIM  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    // Result codes.
    typedef enum logic [2:0] {
        OUT_PUSHED    = 3'd0,
        OUT_MATCHED   = 3'd1,
        OUT_DISCARDED = 3'd2,
        OUT_DONE      = 3'd3,
        OUT_OVERFLOW  = 3'd4
    } t_outcome;

    // Move applied to all cells of the chain in the same cycle.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2
    } t_shift;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } t_state;

    // What the sequencer does in each evaluation cycle.
    typedef enum logic [2:0] {
        STEP_PUSH      = 3'd0,
        STEP_MATCH     = 3'd1,
        STEP_DISCARD   = 3'd2,
        STEP_POP_AGAIN = 3'd3,
        STEP_TRIM_POP  = 3'd4,
        STEP_TRIM_END  = 3'd5,
        STEP_CLEAR     = 3'd6,
        STEP_NOP       = 3'd7
    } t_step;

endpackage

// ----- hdl/pbs_cell.sv -----
// One stack cell: holds an entry and takes its neighbor's entry on a push or pop.
module pbs_cell #(
    parameter int unsigned ENTRY_W = 18
) (
    input  logic                 i_clk,
    input  pbs_pkg::t_shift      i_shift,
    input  logic [ENTRY_W-1:0]   i_from_above,
    input  logic [ENTRY_W-1:0]   i_from_below,
    output logic [ENTRY_W-1:0]   o_entry
);

    logic [ENTRY_W-1:0] r_entry;

    // A push moves entries away from the top, a pop moves them toward it.
    always_ff @(posedge i_clk) begin
        case (i_shift)
            pbs_pkg::SH_PUSH: r_entry <= i_from_above;
            pbs_pkg::SH_POP:  r_entry <= i_from_below;
            default:          r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/priority_bracket_stack_unit.sv -----
// Priority bracket stack: a sequencer over a shifting chain of stack cells.
//
// Requests enter on the input channel (i_in_valid / o_in_ready) and each one
// gives exactly one result on the output channel (o_out_valid / i_out_ready).
// A token request is resolved against the top entry; trim pops plain
// single-line left entries; clear empties the stack.
// The unit works on one request at a time. After acceptance it runs one
// evaluation step of the shared top-of-stack compare per cycle, unless the
// last step is stalled: a token takes 1 + (number of entries it forces off
// by rank) steps, a trim takes 1 + (entries trimmed) steps, clear and the
// unused opcode take one step. The result is registered at the end of the
// last step, and the sequencer then returns to idle to take the next request.
// The result register is separate from the sequencer: a new request may be
// accepted while a result is still waiting. If the receiver stalls, the last
// step waits until the result register is free.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending
// result; the cell contents themselves are not cleared.
module priority_bracket_stack_unit #(
    parameter int unsigned STACK_DEPTH = pbs_pkg::DEF_STACK_DEPTH,
    parameter int unsigned PAIR_KINDS  = pbs_pkg::DEF_PAIR_KINDS,
    parameter int unsigned RANK_BITS   = pbs_pkg::DEF_RANK_BITS,
    localparam int unsigned PAIR_BITS  = $clog2(PAIR_KINDS),
    localparam int unsigned LVL_BITS   = $clog2(STACK_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [PAIR_BITS-1:0] i_pair_id,
    input  logic                 i_is_left,
    input  logic                 i_is_triplet,
    input  logic                 i_balanced,
    input  logic                 i_multi_line,
    input  logic [RANK_BITS-1:0] i_rank,
    input  logic                 i_preprocess,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_outcome,
    output logic [LVL_BITS-1:0]  o_popped_count,
    output logic [LVL_BITS-1:0]  o_stack_level,
    output logic [PAIR_BITS-1:0] o_top_pair_id,
    output logic                 o_top_valid
);

    // Entry layout: pair id, left, triplet, balanced, multi-line, rank.
    localparam int unsigned POS_CROSS = RANK_BITS;
    localparam int unsigned POS_BAL   = RANK_BITS + 1;
    localparam int unsigned POS_TRIP  = RANK_BITS + 2;
    localparam int unsigned POS_LEFT  = RANK_BITS + 3;
    localparam int unsigned POS_PAIR  = RANK_BITS + 4;
    localparam int unsigned ENTRY_W   = PAIR_BITS + 4 + RANK_BITS;

    pbs_pkg::t_state      r_state, n_state;
    pbs_pkg::t_opcode     r_op;
    logic [ENTRY_W-1:0]   r_tok;
    logic                 r_pre;
    logic [LVL_BITS-1:0]  r_count, n_count;
    logic [LVL_BITS-1:0]  r_popped, n_popped;

    logic                 r_out_valid;
    pbs_pkg::t_outcome    r_out_outcome, n_outcome;
    logic [LVL_BITS-1:0]  r_out_popped;
    logic [LVL_BITS-1:0]  r_out_level;
    logic [PAIR_BITS-1:0] r_out_top_id, n_top_id;
    logic                 r_out_top_valid;

    logic [ENTRY_W-1:0]   w_cell_q [STACK_DEPTH];
    pbs_pkg::t_shift      w_shift;
    pbs_pkg::t_step       w_step;
    logic                 w_accept;
    logic                 w_empty, w_full;
    logic                 w_finish, w_slot_free, w_fire;

    logic [PAIR_BITS-1:0] w_top_pair, w_tok_pair;
    logic [RANK_BITS-1:0] w_top_rank, w_tok_rank;
    logic                 w_top_left, w_top_trip, w_top_bal, w_top_cross;
    logic                 w_tok_left, w_tok_bal;

    assign o_in_ready = (r_state == pbs_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Field views of the top cell and the held token.
    assign w_top_pair  = w_cell_q[0][POS_PAIR +: PAIR_BITS];
    assign w_top_left  = w_cell_q[0][POS_LEFT];
    assign w_top_trip  = w_cell_q[0][POS_TRIP];
    assign w_top_bal   = w_cell_q[0][POS_BAL];
    assign w_top_cross = w_cell_q[0][POS_CROSS];
    assign w_top_rank  = w_cell_q[0][RANK_BITS-1:0];
    assign w_tok_pair  = r_tok[POS_PAIR +: PAIR_BITS];
    assign w_tok_left  = r_tok[POS_LEFT];
    assign w_tok_bal   = r_tok[POS_BAL];
    assign w_tok_rank  = r_tok[RANK_BITS-1:0];

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == LVL_BITS'(STACK_DEPTH));

    // Decide this cycle's step from the opcode and the top entry.
    always_comb begin
        w_step = pbs_pkg::STEP_NOP;
        case (r_op)
            pbs_pkg::OP_TOKEN: begin
                if (w_empty) begin
                    w_step = pbs_pkg::STEP_PUSH;
                end else if (r_pre && (w_top_bal || w_tok_bal)) begin
                    w_step = pbs_pkg::STEP_PUSH;
                end else if (w_top_pair == w_tok_pair) begin
                    if (w_tok_bal || (w_top_left && !w_tok_left)) begin
                        w_step = pbs_pkg::STEP_MATCH;
                    end else begin
                        w_step = pbs_pkg::STEP_PUSH;
                    end
                end else if (w_top_left && (w_top_rank > w_tok_rank)) begin
                    w_step = pbs_pkg::STEP_DISCARD;
                end else if (!w_tok_left && (w_top_rank <= w_tok_rank)) begin
                    w_step = pbs_pkg::STEP_POP_AGAIN;
                end else begin
                    w_step = pbs_pkg::STEP_PUSH;
                end
            end
            pbs_pkg::OP_TRIM: begin
                if (!w_empty && w_top_left && !w_top_trip && !w_top_cross) begin
                    w_step = pbs_pkg::STEP_TRIM_POP;
                end else begin
                    w_step = pbs_pkg::STEP_TRIM_END;
                end
            end
            pbs_pkg::OP_CLEAR: w_step = pbs_pkg::STEP_CLEAR;
            default:           w_step = pbs_pkg::STEP_NOP;
        endcase
    end

    // A step that pops and goes on never needs the result register.
    assign w_finish    = (w_step != pbs_pkg::STEP_POP_AGAIN) &&
                         (w_step != pbs_pkg::STEP_TRIM_POP);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_fire      = (r_state == pbs_pkg::ST_EVAL) && (!w_finish || w_slot_free);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = pbs_pkg::ST_EVAL;
                end
            end
            pbs_pkg::ST_EVAL: begin
                if (w_fire && w_finish) begin
                    n_state = pbs_pkg::ST_IDLE;
                end
            end
            default: n_state = pbs_pkg::ST_IDLE;
        endcase
    end

    // Stack moves, level, pop count and result fields of the current step.
    always_comb begin
        w_shift   = pbs_pkg::SH_HOLD;
        n_count   = r_count;
        n_popped  = r_popped;
        n_outcome = pbs_pkg::OUT_DONE;
        n_top_id  = w_top_pair;
        case (w_step)
            pbs_pkg::STEP_PUSH: begin
                if (w_full) begin
                    n_outcome = pbs_pkg::OUT_OVERFLOW;
                end else begin
                    w_shift   = pbs_pkg::SH_PUSH;
                    n_count   = r_count + LVL_BITS'(1);
                    n_outcome = pbs_pkg::OUT_PUSHED;
                    n_top_id  = w_tok_pair;
                end
            end
            pbs_pkg::STEP_MATCH, pbs_pkg::STEP_POP_AGAIN, pbs_pkg::STEP_TRIM_POP: begin
                w_shift   = pbs_pkg::SH_POP;
                n_count   = r_count - LVL_BITS'(1);
                n_popped  = r_popped + LVL_BITS'(1);
                n_top_id  = w_cell_q[1][POS_PAIR +: PAIR_BITS];
                if (w_step == pbs_pkg::STEP_MATCH) begin
                    n_outcome = pbs_pkg::OUT_MATCHED;
                end
            end
            pbs_pkg::STEP_DISCARD: n_outcome = pbs_pkg::OUT_DISCARDED;
            pbs_pkg::STEP_CLEAR: begin
                n_count  = '0;
                n_popped = r_count;
            end
            default: n_outcome = pbs_pkg::OUT_DONE;
        endcase
        if (!w_fire) begin
            w_shift = pbs_pkg::SH_HOLD;
        end
        if (n_count == '0) begin
            n_top_id = '0;
        end
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbs_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count <= n_count;
            end
        end
    end

    // Request capture and running pop count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= pbs_pkg::t_opcode'(i_opcode);
            r_pre    <= i_preprocess;
            r_tok    <= {i_pair_id, i_is_left, i_is_triplet, i_balanced,
                         i_multi_line, i_rank};
            r_popped <= '0;
        end else if (w_fire) begin
            r_popped <= n_popped;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_finish) begin
            r_out_outcome   <= n_outcome;
            r_out_popped    <= n_popped;
            r_out_level     <= n_count;
            r_out_top_id    <= n_top_id;
            r_out_top_valid <= (n_count != '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_popped_count = r_out_popped;
    assign o_stack_level  = r_out_level;
    assign o_top_pair_id  = r_out_top_id;
    assign o_top_valid    = r_out_top_valid;

    // Chain of cells; cell 0 is the top of the stack.
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [ENTRY_W-1:0] w_above, w_below;
        if (k == 0) begin : g_first
            assign w_above = r_tok;
        end else begin : g_mid_above
            assign w_above = w_cell_q[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_below = w_cell_q[k];
        end else begin : g_mid_below
            assign w_below = w_cell_q[k+1];
        end
        pbs_cell #(
            .ENTRY_W (ENTRY_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_shift),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_cell_q[k])
        );
    end

endmodule

// ----- hdl/pbs_checker.sv -----
// Port-level checks for the priority bracket stack, bound to the top level.
module pbs_checker #(
    parameter int unsigned STACK_DEPTH = pbs_pkg::DEF_STACK_DEPTH,
    parameter int unsigned PAIR_KINDS  = pbs_pkg::DEF_PAIR_KINDS,
    localparam int unsigned PAIR_BITS  = $clog2(PAIR_KINDS),
    localparam int unsigned LVL_BITS   = $clog2(STACK_DEPTH + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [2:0]           o_outcome,
    input logic [LVL_BITS-1:0]  o_popped_count,
    input logic [LVL_BITS-1:0]  o_stack_level,
    input logic [PAIR_BITS-1:0] o_top_pair_id,
    input logic                 o_top_valid
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
        $stable(o_outcome) && $stable(o_popped_count) && $stable(o_stack_level))
        else $error("stalled result changed");

    // The top flag agrees with the level, and an empty stack reports id zero.
    a_top_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_top_valid == (o_stack_level != '0)) &&
        (o_top_valid || (o_top_pair_id == '0)))
        else $error("top flag disagrees with level");

    // A match always removes at least one entry.
    a_match_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == pbs_pkg::OUT_MATCHED) |-> (o_popped_count != '0))
        else $error("match without a pop");

    // One request at a time: the cycle after a request is taken is never ready.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in progress");

endmodule

bind priority_bracket_stack_unit pbs_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .PAIR_KINDS  (PAIR_KINDS)
) u_pbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_outcome      (o_outcome),
    .o_popped_count (o_popped_count),
    .o_stack_level  (o_stack_level),
    .o_top_pair_id  (o_top_pair_id),
    .o_top_valid    (o_top_valid)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the priority bracket stack unit.
`timescale 1ns / 100ps

module tb;
    import pbs_pkg::*;

    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int PAIR_W      = $clog2(DEF_PAIR_KINDS);
    localparam int RANK_W      = DEF_RANK_BITS;
    localparam int LVL_W       = $clog2(DEF_STACK_DEPTH + 1);
    localparam int N_ITEMS     = 1700;
    localparam int QUIET_LIMIT = 3000;
    localparam int DIR_ROWS    = 23;

    // One request as driven on the input channel.
    typedef struct {
        t_opcode           opcode;
        logic [PAIR_W-1:0] pair_id;
        logic              is_left;
        logic              is_triplet;
        logic              balanced;
        logic              multi_line;
        logic [RANK_W-1:0] rank;
        logic              preprocess;
    } t_req;

    // One result as seen on the output channel.
    typedef struct {
        t_outcome          outcome;
        logic [LVL_W-1:0]  popped;
        logic [LVL_W-1:0]  level;
        logic [PAIR_W-1:0] top_id;
        logic              top_valid;
    } t_res;

    // A directed row; rows marked fixed carry a hand-written result.
    typedef struct {
        t_req rq;
        bit   fixed;
        t_res res;
    } t_dir_row;

    // One stack cell of the local copy of the stack.
    typedef struct {
        logic [PAIR_W-1:0] pair_id;
        logic              is_left;
        logic              is_triplet;
        logic              balanced;
        logic              multi_line;
        logic [RANK_W-1:0] rank;
    } t_bracket;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_opcode     = '0;
    logic [PAIR_W-1:0] i_pair_id    = '0;
    logic              i_is_left    = 1'b0;
    logic              i_is_triplet = 1'b0;
    logic              i_balanced   = 1'b0;
    logic              i_multi_line = 1'b0;
    logic [RANK_W-1:0] i_rank       = '0;
    logic              i_preprocess = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [2:0]        o_outcome;
    logic [LVL_W-1:0]  o_popped_count;
    logic [LVL_W-1:0]  o_stack_level;
    logic [PAIR_W-1:0] o_top_pair_id;
    logic              o_top_valid;

    t_bracket bracket_stack [DEPTH];
    int       bracket_level = 0;
    t_res     awaited_results [$];
    int       n_sent        = 0;
    int       n_errors      = 0;
    int       quiet_cycles  = 0;
    bit       calm          = 1'b0;

    // Directed requests: empty-stack cases, field extremes, every rule in turn.
    t_dir_row dir_tab [DIR_ROWS] = '{
        // Trim, clear and the unused opcode on an empty stack.
        '{'{OP_TRIM,  0, 0, 0, 0, 0, 0, 0}, 1'b1, '{OUT_DONE, 0, 0, 0, 0}},
        '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{OUT_DONE, 0, 0, 0, 0}},
        '{'{OP_RSVD, 63, 1, 1, 1, 1, 255, 1}, 1'b1, '{OUT_DONE, 0, 0, 0, 0}},
        // Top-rank left token on an empty stack, then a low-rank right is dropped.
        '{'{OP_TOKEN, 63, 1, 1, 0, 1, 255, 1}, 1'b1, '{OUT_PUSHED, 0, 1, 63, 1}},
        '{'{OP_TOKEN, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{OUT_DISCARDED, 0, 1, 63, 1}},
        // Trim stops at a triplet entry; the matching right closes it.
        '{'{OP_TRIM, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{OUT_DONE, 0, 1, 63, 1}},
        '{'{OP_TOKEN, 63, 0, 0, 0, 0, 0, 0}, 1'b1, '{OUT_MATCHED, 1, 0, 0, 0}},
        // A high-rank right forces two lower lefts off, then is pushed.
        '{'{OP_TOKEN, 5, 1, 0, 0, 0, 10, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 6, 1, 0, 0, 0, 20, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 9, 0, 0, 0, 0, 200, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        // A balanced token with the top's pair id matches.
        '{'{OP_TOKEN, 9, 1, 0, 1, 0, 0, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        // Preprocess mode pushes a balanced token; without it the token matches.
        '{'{OP_TOKEN, 3, 1, 0, 1, 0, 50, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 3, 1, 0, 1, 0, 50, 1}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 3, 1, 0, 1, 0, 50, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        // Trim takes plain lefts (same id twice) and stops at a multi-line one.
        '{'{OP_TOKEN, 7, 1, 0, 0, 1, 60, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 8, 1, 0, 0, 0, 61, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 8, 1, 0, 0, 0, 61, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TRIM, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        // Equal rank pops the top, a lower left below goes too, then it is pushed.
        '{'{OP_TOKEN, 40, 0, 0, 0, 0, 60, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        // Rights pop each other by rank; a left sits on a right top.
        '{'{OP_TOKEN, 20, 0, 0, 0, 0, 100, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 21, 0, 0, 0, 0, 100, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_TOKEN, 22, 1, 0, 0, 0, 0, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}},
        '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{OUT_PUSHED, 0, 0, 0, 0}}
    };

    priority_bracket_stack_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_pair_id      (i_pair_id),
        .i_is_left      (i_is_left),
        .i_is_triplet   (i_is_triplet),
        .i_balanced     (i_balanced),
        .i_multi_line   (i_multi_line),
        .i_rank         (i_rank),
        .i_preprocess   (i_preprocess),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_popped_count (o_popped_count),
        .o_stack_level  (o_stack_level),
        .o_top_pair_id  (o_top_pair_id),
        .o_top_valid    (o_top_valid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Resolves one request against the local stack and returns its result.
    task automatic resolve_request(input t_req rq, output t_res rs);
        t_bracket tok;
        t_bracket top;
        bit       done;
        bit       want_push;
        tok = '{rq.pair_id, rq.is_left, rq.is_triplet, rq.balanced, rq.multi_line, rq.rank};
        rs.outcome = OUT_DONE;
        rs.popped  = '0;
        case (rq.opcode)
            OP_TOKEN: begin
                done = 1'b0;
                while (!done) begin
                    want_push = 1'b0;
                    if (bracket_level == 0) begin
                        want_push = 1'b1;
                    end else begin
                        top = bracket_stack[bracket_level - 1];
                        if (rq.preprocess && (top.balanced || tok.balanced)) begin
                            want_push = 1'b1;
                        end else if (top.pair_id == tok.pair_id) begin
                            if (tok.balanced || (top.is_left && !tok.is_left)) begin
                                bracket_level--;
                                rs.popped++;
                                rs.outcome = OUT_MATCHED;
                                done = 1'b1;
                            end else begin
                                want_push = 1'b1;
                            end
                        end else if (top.is_left && top.rank > tok.rank) begin
                            rs.outcome = OUT_DISCARDED;
                            done = 1'b1;
                        end else if (!tok.is_left && top.rank <= tok.rank) begin
                            // Forced off by rank; look at the next entry down.
                            bracket_level--;
                            rs.popped++;
                        end else begin
                            want_push = 1'b1;
                        end
                    end
                    if (want_push) begin
                        if (bracket_level < DEPTH) begin
                            bracket_stack[bracket_level] = tok;
                            bracket_level++;
                            rs.outcome = OUT_PUSHED;
                        end else begin
                            rs.outcome = OUT_OVERFLOW;
                        end
                        done = 1'b1;
                    end
                end
            end
            OP_TRIM: begin
                while (bracket_level > 0 && bracket_stack[bracket_level - 1].is_left &&
                       !bracket_stack[bracket_level - 1].is_triplet &&
                       !bracket_stack[bracket_level - 1].multi_line) begin
                    bracket_level--;
                    rs.popped++;
                end
            end
            OP_CLEAR: begin
                rs.popped     = LVL_W'(bracket_level);
                bracket_level = 0;
            end
            default: begin
            end
        endcase
        rs.level     = LVL_W'(bracket_level);
        rs.top_valid = (bracket_level != 0);
        rs.top_id    = (bracket_level != 0) ? bracket_stack[bracket_level - 1].pair_id : '0;
    endtask

    // Token request with every field random.
    function automatic t_req rand_token();
        t_req r;
        r.opcode     = OP_TOKEN;
        r.pair_id    = PAIR_W'($urandom_range(63));
        r.is_left    = 1'($urandom_range(1));
        r.is_triplet = 1'($urandom_range(1));
        r.balanced   = 1'($urandom_range(1));
        r.multi_line = 1'($urandom_range(1));
        r.rank       = RANK_W'($urandom_range(255));
        r.preprocess = 1'($urandom_range(1));
        return r;
    endfunction

    // Drives one request until accepted, then queues its expected result.
    task automatic issue_request(input t_req rq, input bit fixed, input t_res fixed_res);
        t_res predicted;
        if (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= rq.opcode;
        i_pair_id    <= rq.pair_id;
        i_is_left    <= rq.is_left;
        i_is_triplet <= rq.is_triplet;
        i_balanced   <= rq.balanced;
        i_multi_line <= rq.multi_line;
        i_rank       <= rq.rank;
        i_preprocess <= rq.preprocess;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        resolve_request(rq, predicted);
        awaited_results.push_back(fixed ? fixed_res : predicted);
        n_sent++;
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Stimulus: reset, directed table, then random sequences.
    initial begin
        int                k;
        int                depth;
        int                pick;
        int                rank_floor;
        t_req              rq;
        t_res              no_res;
        logic [PAIR_W-1:0] open_ids [8];
        no_res = '{OUT_PUSHED, '0, '0, '0, 1'b0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            issue_request(dir_tab[k].rq, dir_tab[k].fixed, dir_tab[k].res);
        end

        while (n_sent < N_ITEMS) begin
            calm = (n_sent >= 800 && n_sent < 1000);
            pick = $urandom_range(99);
            if (pick < 55) begin
                // Nested opens with a rank that never falls, closed in reverse order.
                depth      = $urandom_range(8, 1);
                rank_floor = $urandom_range(63);
                for (k = 0; k < depth; k++) begin
                    rq            = rand_token();
                    rq.is_left    = 1'b1;
                    rq.balanced   = ($urandom_range(9) == 0);
                    rq.preprocess = ($urandom_range(3) == 0);
                    rank_floor    = rank_floor + $urandom_range(24);
                    if (rank_floor > 255) rank_floor = 255;
                    rq.rank       = RANK_W'(rank_floor);
                    open_ids[k]   = rq.pair_id;
                    issue_request(rq, 1'b0, no_res);
                end
                for (k = depth - 1; k >= 0; k--) begin
                    rq          = rand_token();
                    rq.is_left  = 1'b0;
                    rq.balanced = 1'b0;
                    rq.pair_id  = open_ids[k];
                    // Now and then a wrong close or a missing one.
                    if ($urandom_range(9) == 0) rq.pair_id = PAIR_W'($urandom_range(63));
                    if ($urandom_range(9) != 0) issue_request(rq, 1'b0, no_res);
                end
            end else if (pick < 80) begin
                issue_request(rand_token(), 1'b0, no_res);
            end else if (pick < 88) begin
                rq        = rand_token();
                rq.opcode = OP_TRIM;
                issue_request(rq, 1'b0, no_res);
            end else if (pick < 93) begin
                rq        = rand_token();
                rq.opcode = OP_CLEAR;
                issue_request(rq, 1'b0, no_res);
            end else if (pick < 95) begin
                rq        = rand_token();
                rq.opcode = OP_RSVD;
                issue_request(rq, 1'b0, no_res);
            end else if (pick < 97) begin
                // Fill the stack past full, then pop it down with one top-rank right.
                rq        = rand_token();
                rq.opcode = OP_CLEAR;
                issue_request(rq, 1'b0, no_res);
                for (k = 0; k < DEPTH + 2; k++) begin
                    rq          = rand_token();
                    rq.is_left  = 1'b1;
                    rq.balanced = 1'b0;
                    rq.rank     = '0;
                    issue_request(rq, 1'b0, no_res);
                end
                rq          = rand_token();
                rq.is_left  = 1'b0;
                rq.balanced = 1'b0;
                rq.rank     = '1;
                issue_request(rq, 1'b0, no_res);
            end else begin
                // Right tokens with the extreme ranks.
                rq         = rand_token();
                rq.is_left = 1'b0;
                rq.rank    = $urandom_range(1) ? '1 : '0;
                issue_request(rq, 1'b0, no_res);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then watch a little longer for stray results.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side stalls at random except during the calm stretch.
    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_result
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no request pending", o_outcome, -1);
            end else begin
                want = awaited_results.pop_front();
                if (o_outcome !== want.outcome)
                    report_mismatch("outcome", o_outcome, want.outcome);
                if (o_popped_count !== want.popped)
                    report_mismatch("popped_count", o_popped_count, want.popped);
                if (o_stack_level !== want.level)
                    report_mismatch("stack_level", o_stack_level, want.level);
                if (o_top_pair_id !== want.top_id)
                    report_mismatch("top_pair_id", o_top_pair_id, want.top_id);
                if (o_top_valid !== want.top_valid)
                    report_mismatch("top_valid", o_top_valid, want.top_valid);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
hdl/pbs_pkg.sv
hdl/pbs_cell.sv
hdl/priority_bracket_stack_unit.sv
hdl/pbs_checker.sv
dv/tb.sv
